/* design/rfbg_pkg.sv */
// Shared types and constants for the rectangle fill, blend and gradient engine.
`default_nettype none
package rfbg_pkg;
    localparam logic [31:0] CLEAR_COLOR = 32'hFF11111B;
    localparam logic [31:0] OPAQUE   = 32'hFF000000;
    localparam logic [1:0] KIND_FILL = 2'd0;
    localparam logic [1:0] KIND_GRAD = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_NOP  = 2'd3;
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PITCH  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic signed [11:0] rect_w;
        logic signed [11:0] rect_h;
        logic [31:0]        color_a;
        logic [31:0]        color_b;
    } t_cmd;

    typedef struct packed {
        logic [31:0] read_data;
        logic        done_res;
    } t_res;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]         op;      // KIND_* code; anything else is a no-op
        logic signed [12:0] r0;
        logic signed [12:0] r1;
        logic signed [12:0] c0;
        logic signed [12:0] c1;
        logic [11:0]        j0;      // gradient row index of r0
        logic [11:0]        h;
        logic               blend;
        logic [31:0]        color_a;
        logic [31:0]        color_b;
    } t_job;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROW, S_T, S_CH, S_PIX, S_RD0, S_RD1, S_RD2, S_BL, S_OUT
    } t_state;

    // x / 255 for x < 65280.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] q;
        q = ({1'b0, x} + 17'd1 + {9'd0, x[15:8]}) >> 8;
        return q[7:0];
    endfunction
endpackage
`default_nettype wire

/* design/rfbg_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module rfbg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* design/rfbg_front.sv */
// Command intake: clipping and classification into a two-entry job queue.
`default_nettype none
module rfbg_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire rfbg_pkg::t_cmd   i_cmd,
    input  wire [10:0]            i_width,
    input  wire [10:0]            i_height,
    output logic                  o_job_valid,
    input  wire                   i_job_ready,
    output rfbg_pkg::t_job        o_job
);
    rfbg_pkg::t_job r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    rfbg_pkg::t_job job;
    logic signed [12:0] x, y, w, h, e_r, e_c, sh, sw;
    logic push, pop;

    always_comb begin
        x  = {i_cmd.pos_x[11], i_cmd.pos_x};
        y  = {i_cmd.pos_y[11], i_cmd.pos_y};
        w  = {i_cmd.rect_w[11], i_cmd.rect_w};
        h  = {i_cmd.rect_h[11], i_cmd.rect_h};
        sh = {2'b00, i_height};
        sw = {2'b00, i_width};
        e_r = y + h;
        e_c = x + w;
        job.op      = i_cmd.kind;
        job.r0      = y[12] ? 13'sd0 : y;
        job.r1      = (e_r > sh) ? sh : e_r;
        job.c0      = x[12] ? 13'sd0 : x;
        job.c1      = (e_c > sw) ? sw : e_c;
        job.j0      = y[12] ? 12'(-y) : 12'd0;
        job.h       = i_cmd.rect_h[11:0];
        job.blend   = (i_cmd.color_a[31:24] != 8'h00) && (i_cmd.color_a[31:24] != 8'hFF);
        job.color_a = i_cmd.color_a;
        job.color_b = i_cmd.color_b;
        if ((i_cmd.kind == rfbg_pkg::KIND_FILL || i_cmd.kind == rfbg_pkg::KIND_GRAD)
            && (w[12] || w == 13'sd0 || h[12] || h == 13'sd0)) begin
            job.r1 = job.r0;
        end
        if (i_cmd.kind == rfbg_pkg::KIND_READ) begin
            job.r0 = y;
            job.c0 = x;
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* design/rfbg_back.sv */
// Drawing sequencer: clears the store, then walks pixels of each job or serves a read.
`default_nettype none
module rfbg_back #(
    parameter int MEM_WORDS = 524288
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_job_valid,
    output logic                 o_job_ready,
    input  wire rfbg_pkg::t_job  i_job,
    input  wire [10:0]           i_pitch,
    output logic                 o_valid,
    input  wire                  i_ready,
    output rfbg_pkg::t_res       o_res
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [23:0] LIMIT = 24'(MEM_WORDS);

    rfbg_pkg::t_state r_st, n_st;
    rfbg_pkg::t_job   r_job, n_job;
    logic signed [12:0] r_r, n_r, r_c, n_c;
    logic [11:0] r_j, n_j;
    logic [7:0]  r_t, n_t;
    logic [19:0] r_num, n_num;          // j*255 remainder divider
    logic [2:0]  r_k, n_k;
    logic [31:0] r_px, n_px;
    logic [23:0] r_addr, n_addr;
    logic [AW-1:0] r_ca, n_ca;
    logic        r_ov, n_ov;
    rfbg_pkg::t_res r_out, n_out;

    logic [AW-1:0] m_addr;
    logic          m_we;
    logic [31:0]   m_wd, m_rd;
    logic [23:0]   a_full;
    logic [19:0]   dsh;
    logic [15:0]   p_r, p_g, p_b;
    logic [7:0]    ia;

    rfbg_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
        .i_clk(i_clk), .i_we(m_we), .i_addr(m_addr), .i_wdata(m_wd), .o_rdata(m_rd)
    );

    always_ff @(posedge i_clk) begin
        r_job <= n_job; r_r <= n_r; r_c <= n_c; r_j <= n_j; r_t <= n_t;
        r_num <= n_num; r_k <= n_k; r_px <= n_px; r_addr <= n_addr; r_out <= n_out;
        if (!i_rst_n) begin
            r_st <= rfbg_pkg::S_CLEAR;
            r_ca <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ca <= n_ca;
            r_ov <= n_ov;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_out;
    assign o_job_ready = (r_st == rfbg_pkg::S_IDLE) && !r_ov;

    always_comb begin
        n_st = r_st; n_job = r_job; n_r = r_r; n_c = r_c; n_j = r_j; n_t = r_t;
        n_num = r_num; n_k = r_k; n_px = r_px; n_addr = r_addr; n_out = r_out;
        n_ca = r_ca; n_ov = r_ov && !i_ready;
        m_we = 1'b0; m_addr = r_addr[AW-1:0]; m_wd = r_px;
        a_full = 24'(r_r[11:0]) * 24'(i_pitch) + 24'(r_c[11:0]);
        dsh = {8'd0, r_job.h} << (3'd7 - r_k);
        ia = 8'hFF - r_job.color_a[31:24];
        p_r = 16'(r_job.color_a[23:16]) * 16'(r_job.color_a[31:24])
            + 16'(m_rd[23:16]) * 16'(ia);
        p_g = 16'(r_job.color_a[15:8]) * 16'(r_job.color_a[31:24])
            + 16'(m_rd[15:8]) * 16'(ia);
        p_b = 16'(r_job.color_a[7:0]) * 16'(r_job.color_a[31:24])
            + 16'(m_rd[7:0]) * 16'(ia);
        unique case (r_st)
            rfbg_pkg::S_CLEAR: begin
                m_we = 1'b1; m_addr = r_ca; m_wd = rfbg_pkg::CLEAR_COLOR;
                n_ca = r_ca + AW'(1);
                if (r_ca == AW'(MEM_WORDS - 1)) n_st = rfbg_pkg::S_IDLE;
            end
            rfbg_pkg::S_IDLE: begin
                if (i_job_valid && !r_ov) begin
                    n_job = i_job; n_r = i_job.r0; n_c = i_job.c0; n_j = i_job.j0;
                    n_out = '{read_data: 32'd0, done_res: 1'b1};
                    unique case (i_job.op)
                        rfbg_pkg::KIND_READ: n_st = rfbg_pkg::S_RD0;
                        rfbg_pkg::KIND_FILL: n_st = rfbg_pkg::S_ROW;
                        rfbg_pkg::KIND_GRAD: n_st = rfbg_pkg::S_ROW;
                        default:             n_st = rfbg_pkg::S_OUT;
                    endcase
                end
            end
            rfbg_pkg::S_ROW: begin
                n_c = r_job.c0;
                if (r_r >= r_job.r1 || r_job.c0 >= r_job.c1) begin
                    n_st = rfbg_pkg::S_OUT;
                end else if (r_job.op == rfbg_pkg::KIND_GRAD) begin
                    n_num = {r_j, 8'd0} - {8'd0, r_j}; // j*255
                    n_t = 8'd0; n_k = 3'd0;
                    n_st = rfbg_pkg::S_T;
                end else begin
                    n_px = r_job.color_a | rfbg_pkg::OPAQUE;
                    n_st = rfbg_pkg::S_PIX;
                end
            end
            rfbg_pkg::S_T: begin
                // restoring division j*255 / h, one quotient bit per cycle
                if (r_num >= dsh) begin
                    n_num = r_num - dsh;
                    n_t = r_t | (8'h80 >> r_k);
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd7) n_st = rfbg_pkg::S_CH;
            end
            rfbg_pkg::S_CH: begin
                n_px = {8'h00,
                    rfbg_pkg::div255(16'(r_job.color_a[23:16]) * 16'(8'hFF - r_t)
                        + 16'(r_job.color_b[23:16]) * 16'(r_t)),
                    rfbg_pkg::div255(16'(r_job.color_a[15:8]) * 16'(8'hFF - r_t)
                        + 16'(r_job.color_b[15:8]) * 16'(r_t)),
                    rfbg_pkg::div255(16'(r_job.color_a[7:0]) * 16'(8'hFF - r_t)
                        + 16'(r_job.color_b[7:0]) * 16'(r_t))};
                n_st = rfbg_pkg::S_PIX;
            end
            rfbg_pkg::S_PIX: begin
                n_addr = a_full;
                if (r_job.blend && r_job.op == rfbg_pkg::KIND_FILL) begin
                    m_addr = a_full[AW-1:0];
                    n_st = rfbg_pkg::S_BL;
                end else begin
                    m_addr = a_full[AW-1:0];
                    m_we = (a_full < LIMIT);
                    n_c = r_c + 13'sd1;
                    if (r_c + 13'sd1 >= r_job.c1) begin
                        n_r = r_r + 13'sd1; n_j = r_j + 12'd1; n_st = rfbg_pkg::S_ROW;
                    end
                end
            end
            rfbg_pkg::S_BL: begin
                m_wd = {8'hFF, rfbg_pkg::div255(p_r), rfbg_pkg::div255(p_g),
                        rfbg_pkg::div255(p_b)};
                m_we = (r_addr < LIMIT);
                n_c = r_c + 13'sd1;
                n_st = rfbg_pkg::S_PIX;
                if (r_c + 13'sd1 >= r_job.c1) begin
                    n_r = r_r + 13'sd1; n_st = rfbg_pkg::S_ROW;
                end
            end
            rfbg_pkg::S_RD0: begin
                n_addr = a_full;
                n_st = (r_r[12] || r_c[12]) ? rfbg_pkg::S_OUT : rfbg_pkg::S_RD1;
            end
            rfbg_pkg::S_RD1: begin
                n_st = (r_addr < LIMIT) ? rfbg_pkg::S_RD2 : rfbg_pkg::S_OUT;
            end
            rfbg_pkg::S_RD2: begin
                n_out.read_data = m_rd;
                n_st = rfbg_pkg::S_OUT;
            end
            rfbg_pkg::S_OUT: begin
                n_ov = 1'b1;
                n_st = rfbg_pkg::S_IDLE;
            end
            default: n_st = rfbg_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* design/rect_fill_blend_gradient_engine.sv */
// Top level of the rectangle fill, blend and gradient engine.
// After reset the pixel store is swept to the background color, one word per
// cycle, before the first command is drawn. An opaque fill or gradient writes
// one pixel per cycle within a row through the single RAM port, and gradient
// rows first pass through the row-weight divider; a blended fill reads then
// writes each pixel; a read checks its address, then fetches the stored word.
// A two-entry queue decouples intake from drawing.
`default_nettype none
module rect_fill_blend_gradient_engine #(
    parameter int MEM_WORDS = 524288
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire rfbg_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire                 i_ready,
    output rfbg_pkg::t_res      o_res,
    input  wire                 i_cfg_we,
    input  wire [1:0]           i_cfg_index,
    input  wire [10:0]          i_cfg_data
);
    logic [10:0] r_width, r_height, r_pitch;
    logic job_valid, job_ready;
    rfbg_pkg::t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 11'd640; r_height <= 11'd480; r_pitch <= 11'd640;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rfbg_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                rfbg_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                rfbg_pkg::CFG_PITCH:  r_pitch  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rfbg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_width(r_width), .i_height(r_height),
        .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job)
    );

    rfbg_back #(.MEM_WORDS(MEM_WORDS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid),
        .o_job_ready(job_ready), .i_job(job), .i_pitch(r_pitch),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
    );

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.done_res) else $error("result without done");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res)) else $error("result dropped");
endmodule
`default_nettype wire

/* test/tb_rect_fill_blend_gradient_engine.sv */
// Self-checking testbench for the rectangle fill, blend and gradient engine.
`timescale 1ns / 100ps
`default_nettype none
module tb_rect_fill_blend_gradient_engine;
    localparam int MEM_WORDS  = 524288;
    localparam int IDLE_LIMIT = 2000000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    rfbg_pkg::t_cmd  i_cmd;
    logic            o_valid;
    logic            i_ready;
    rfbg_pkg::t_res  o_res;
    logic            i_cfg_we;
    logic [1:0]      i_cfg_index;
    logic [10:0]     i_cfg_data;

    rect_fill_blend_gradient_engine #(.MEM_WORDS(MEM_WORDS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(i_cmd),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [31:0]    pix_mem [0:MEM_WORDS-1];
    int             scr_w, scr_h, pitch;
    rfbg_pkg::t_res exp_q [$];
    int             err_cnt;
    int             send_idle;
    int             recv_stall;
    int             idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] blend_px(input logic [31:0] fg, input logic [31:0] bg);
        int a;
        int r, g, b;
        a = int'(fg[31:24]);
        r = (fg[23:16] * a + bg[23:16] * (255 - a)) / 255;
        g = (fg[15:8] * a + bg[15:8] * (255 - a)) / 255;
        b = (fg[7:0] * a + bg[7:0] * (255 - a)) / 255;
        return rfbg_pkg::OPAQUE | (r << 16) | (g << 8) | b;
    endfunction

    function automatic longint word_addr(input int col, input int row);
        return longint'(row) * pitch + col;
    endfunction

    task automatic draw_and_read(input rfbg_pkg::t_cmd c, output rfbg_pkg::t_res res);
        int x, y, w, h, r0, r1, c0, c1, rr, cc, t;
        int cr, cg, cb;
        longint ad;
        logic blend;
        logic [31:0] px;
        x = int'(c.pos_x);
        y = int'(c.pos_y);
        w = int'(c.rect_w);
        h = int'(c.rect_h);
        res.read_data = 32'd0;
        res.done_res  = 1'b1;
        c0 = (x < 0) ? 0 : x;
        c1 = (x + w > scr_w) ? scr_w : x + w;
        if (c.kind == rfbg_pkg::KIND_FILL && w > 0 && h > 0) begin
            blend = (c.color_a[31:24] != 8'h00) && (c.color_a[31:24] != 8'hFF);
            r0 = (y < 0) ? 0 : y;
            r1 = (y + h > scr_h) ? scr_h : y + h;
            for (rr = r0; rr < r1; rr++) begin
                for (cc = c0; cc < c1; cc++) begin
                    ad = word_addr(cc, rr);
                    if (ad < MEM_WORDS) begin
                        if (blend) pix_mem[ad] = blend_px(c.color_a, pix_mem[ad]);
                        else pix_mem[ad] = c.color_a | rfbg_pkg::OPAQUE;
                    end
                end
            end
        end else if (c.kind == rfbg_pkg::KIND_GRAD && w > 0 && h > 0) begin
            for (int j = 0; j < h; j++) begin
                rr = y + j;
                if (rr < 0 || rr >= scr_h) continue;
                t  = (j * 255) / h;
                cr = (c.color_a[23:16] * (255 - t) + c.color_b[23:16] * t) / 255;
                cg = (c.color_a[15:8] * (255 - t) + c.color_b[15:8] * t) / 255;
                cb = (c.color_a[7:0] * (255 - t) + c.color_b[7:0] * t) / 255;
                px = (cr << 16) | (cg << 8) | cb;
                for (cc = c0; cc < c1; cc++) begin
                    ad = word_addr(cc, rr);
                    if (ad < MEM_WORDS) pix_mem[ad] = px;
                end
            end
        end else if (c.kind == rfbg_pkg::KIND_READ && x >= 0 && y >= 0) begin
            ad = word_addr(x, y);
            if (ad < MEM_WORDS) res.read_data = pix_mem[ad];
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        rfbg_pkg::t_res want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (exp_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected item: data %h done %b",
                                 o_res.read_data, o_res.done_res);
                end else begin
                    want = exp_q.pop_front();
                    if (o_res.read_data !== want.read_data ||
                        o_res.done_res !== want.done_res) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("mismatch: expected data %h done %b, got %h %b",
                                     want.read_data, want.done_res,
                                     o_res.read_data, o_res.done_res);
                    end
                end
            end
        end
    end

    // Entered and left at a falling edge.
    task automatic send_cmd(input rfbg_pkg::t_cmd c);
        rfbg_pkg::t_res res;
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (!o_ready);
        draw_and_read(c, res);
        exp_q.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic send_one(input logic [1:0] k, input int x, input int y, input int w,
                            input int h, input logic [31:0] ca, input logic [31:0] cb);
        rfbg_pkg::t_cmd c;
        c.kind = k;
        c.pos_x = x[11:0];
        c.pos_y = y[11:0];
        c.rect_w = w[11:0];
        c.rect_h = h[11:0];
        c.color_a = ca;
        c.color_b = cb;
        send_cmd(c);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        wait (exp_q.size() == 0);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[10:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rfbg_pkg::CFG_WIDTH) scr_w = int'(val[10:0]);
        else if (idx == rfbg_pkg::CFG_HEIGHT) scr_h = int'(val[10:0]);
        else pitch = int'(val[10:0]);
    endtask

    task automatic set_screen(input int w, input int h, input int p);
        drain();
        cfg_write(rfbg_pkg::CFG_WIDTH, w);
        cfg_write(rfbg_pkg::CFG_HEIGHT, h);
        cfg_write(rfbg_pkg::CFG_PITCH, p);
    endtask

    function automatic logic [31:0] rand_color;
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: v[31:24] = 8'h00;
            1: v[31:24] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    function automatic int rand_coord(input int lim);
        case ($urandom_range(9))
            0: return int'($signed($urandom_range(4095) - 2048));
            1: return -int'($urandom_range(6));
            default: return $urandom_range((lim + 3 > 2047) ? 2047 : lim + 3);
        endcase
    endfunction

    function automatic int rand_size(input logic wide);
        case ($urandom_range(9))
            0: return wide ? int'($urandom_range(4095)) - 2048 : -int'($urandom_range(3));
            1: return wide ? 2047 : 0;
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic test_directed;
        send_one(rfbg_pkg::KIND_FILL, -3, -3, 6, 6, 32'h00123456, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 0, 0, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_FILL, 1, 1, 4, 3, 32'h80FF00FF, 32'h0);
        send_one(rfbg_pkg::KIND_FILL, 2, 1, 3, 3, 32'h01ABCDEF, 32'h0);
        send_one(rfbg_pkg::KIND_FILL, 3, 2, 2, 2, 32'hFE102030, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 1, 1, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 3, 2, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_FILL, 636, 476, 10, 10, 32'hFFFFFFFF, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 639, 479, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_GRAD, 10, -2, 3, 7, 32'hFFFF0000, 32'h000000FF);
        send_one(rfbg_pkg::KIND_GRAD, 20, 20, 2, 1, 32'h00FFFFFF, 32'h00000000);
        send_one(rfbg_pkg::KIND_READ, 11, 4, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 20, 20, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_READ, -1, 5, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 5, -2048, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 2047, 2047, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 700, 10, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_NOP, 0, 0, 5, 5, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_one(rfbg_pkg::KIND_READ, 0, 0, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_FILL, 0, 0, 0, 5, 32'hFF000000, 32'h0);
        send_one(rfbg_pkg::KIND_GRAD, 0, 0, 5, -2048, 32'hFF000000, 32'hFFFFFFFF);
        send_one(rfbg_pkg::KIND_FILL, 2047, 0, 2047, 2, 32'hFF00FF00, 32'h0);
        send_one(rfbg_pkg::KIND_FILL, -2048, 100, 2, 1, 32'h00000000, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 1, 100, 0, 0, 32'h0, 32'h0);
    endtask

    task automatic test_random(input int n);
        rfbg_pkg::t_cmd c;
        logic wide;
        wide = (scr_w * scr_h <= 1024);
        for (int i = 0; i < n; i++) begin
            c.kind = ($urandom_range(19) == 0) ? rfbg_pkg::KIND_NOP : 2'($urandom_range(2));
            c.pos_x = 12'(rand_coord(scr_w));
            c.pos_y = 12'(rand_coord(scr_h));
            c.rect_w = 12'(rand_size(wide));
            c.rect_h = 12'(rand_size(wide));
            c.color_a = rand_color();
            c.color_b = $urandom;
            send_cmd(c);
        end
    endtask

    task automatic test_reset_screen;
        send_idle = 0;
        recv_stall = 0;
        test_directed();
        test_random(130);
    endtask

    task automatic test_small_screen;
        set_screen(16, 12, 16);
        send_idle = 73;
        recv_stall = 0;
        test_random(130);
        set_screen(1, 1, 1);
        test_random(25);
    endtask

    task automatic test_max_screen;
        set_screen(2047, 2047, 2047);
        send_idle = 0;
        recv_stall = 73;
        send_one(rfbg_pkg::KIND_FILL, 2040, 300, 7, 3, 32'hFF445566, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 2040, 255, 0, 0, 32'h0, 32'h0);
        send_one(rfbg_pkg::KIND_READ, 2045, 300, 0, 0, 32'h0, 32'h0);
        test_random(120);
    endtask

    task automatic test_zero_regs;
        set_screen(0, 5, 1);
        send_idle = 17;
        recv_stall = 17;
        test_random(20);
        set_screen(20, 2047, 0);
        test_random(60);
        set_screen(30, 20, 24);
        test_random(60);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = rfbg_pkg::CFG_WIDTH;
        i_cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        scr_w = 640;
        scr_h = 480;
        pitch = 640;
        for (int i = 0; i < MEM_WORDS; i++) pix_mem[i] = rfbg_pkg::CLEAR_COLOR;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_screen();
        test_small_screen();
        test_max_screen();
        test_zero_regs();
        drain();
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire
